// ----- rtl/assert_macros.svh -----
// assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPL(label, clk, rstn, ante, cons)

`define ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

// ----- rtl/dcdp_pkg.sv -----
package dcdp_pkg;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic       REG_IDX_EXPECTED_TAG = 1'b0;
    localparam logic [7:0] EXPECTED_TAG_RESET   = 8'hC7;
    localparam logic [8:0] HEADER_BYTES         = 9'd2;
    localparam logic [7:0] LANG_LAST_OFFSET     = 8'd2;
    localparam logic [7:0] OFFSET_MAX           = 8'hFF;

    typedef enum logic [3:0] {
        PH_TAG     = 4'd0,
        PH_LEN     = 4'd1,
        PH_CID     = 4'd2,
        PH_ENTRY   = 4'd3,
        PH_SELLEN  = 4'd4,
        PH_SEL     = 4'd5,
        PH_REFCNT  = 4'd6,
        PH_REF     = 4'd7,
        PH_LANG    = 4'd8,
        PH_TEXTLEN = 4'd9,
        PH_TEXT    = 4'd10,
        PH_TRAIL   = 4'd11
    } phase_t;

    typedef enum logic [3:0] {
        CLS_TAG     = 4'd0,
        CLS_LEN     = 4'd1,
        CLS_CID     = 4'd2,
        CLS_ENTRY   = 4'd3,
        CLS_SELLEN  = 4'd4,
        CLS_SEL     = 4'd5,
        CLS_REFCNT  = 4'd6,
        CLS_REF     = 4'd7,
        CLS_LANG    = 4'd8,
        CLS_TEXTLEN = 4'd9,
        CLS_TEXT    = 4'd10,
        CLS_TRAIL   = 4'd11,
        CLS_DISCARD = 4'd12
    } class_t;

    typedef enum logic [2:0] {
        ST_BUSY    = 3'd0,
        ST_OK      = 3'd1,
        ST_BADTAG  = 3'd2,
        ST_TRUNC   = 3'd3,
        ST_ZEROLEN = 3'd4,
        ST_OVERRUN = 3'd5
    } status_t;

endpackage

// ----- rtl/dcdp_cfg.sv -----
module dcdp_cfg (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [dcdp_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [dcdp_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [dcdp_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                              pready,
    output logic [7:0]                        expected_tag
);

    logic [7:0] expected_tag_reg;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready
                    && (paddr[2] == dcdp_pkg::REG_IDX_EXPECTED_TAG);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expected_tag_reg <= dcdp_pkg::EXPECTED_TAG_RESET;
        end else if (wr_en) begin
            expected_tag_reg <= pwdata[7:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == dcdp_pkg::REG_IDX_EXPECTED_TAG) begin
            prdata = {(dcdp_pkg::CFG_DATA_W - 8)'(0), expected_tag_reg};
        end
    end

    assign expected_tag = expected_tag_reg;

endmodule

// ----- rtl/data_content_descriptor_parser_unit.sv -----
// result: each accepted input beat yields one result beat, held in the output register
// throughput: one byte per cycle; s_tready falls only while the output register is full
// and stalled by m_tready
// reset: synchronous active-low aresetn; parser waits for a tag, expected tag returns to 0xC7
`include "assert_macros.svh"

module data_content_descriptor_parser_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // data_byte
    input  logic                              s_tlast,   // end_of_data
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // field_offset[7:0], byte_value[15:8], status[18:16], descriptor_size[27:19], zero[31:28]
    output logic [31:0]                       m_tdata,
    output logic [3:0]                        m_tuser,   // byte_class
    output logic                              m_tlast,   // done_res
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [dcdp_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [dcdp_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [dcdp_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                              pready
);

    logic [7:0] expected_tag;

    dcdp_cfg u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .expected_tag (expected_tag)
    );

    dcdp_pkg::phase_t  phase_reg, phase_next;
    logic [7:0]        body_rem_reg, body_rem_next;
    logic [7:0]        body_len_reg, body_len_next;
    logic [7:0]        field_rem_reg, field_rem_next;
    logic [7:0]        offset_reg, offset_next;
    logic              discard_reg, discard_next;

    dcdp_pkg::class_t  res_cls;
    logic [7:0]        res_off;
    logic              res_done;
    dcdp_pkg::status_t res_st;
    logic [8:0]        res_size;

    logic              out_valid_reg;
    dcdp_pkg::class_t  out_cls_reg;
    logic [7:0]        out_off_reg;
    logic [7:0]        out_byte_reg;
    logic              out_done_reg;
    dcdp_pkg::status_t out_st_reg;
    logic [8:0]        out_size_reg;

    logic accept;
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        dcdp_pkg::phase_t  nxt;
        dcdp_pkg::status_t err;
        logic              do_restart;
        logic [7:0]        fr_dec;
        logic [7:0]        br_dec;

        phase_next     = phase_reg;
        body_rem_next  = body_rem_reg;
        body_len_next  = body_len_reg;
        field_rem_next = field_rem_reg;
        offset_next    = offset_reg;
        discard_next   = discard_reg;
        res_cls        = dcdp_pkg::CLS_TAG;
        res_off        = '0;
        res_done       = 1'b0;
        res_st         = dcdp_pkg::ST_BUSY;
        res_size       = '0;
        err            = dcdp_pkg::ST_BUSY;
        do_restart     = 1'b0;
        nxt            = phase_reg;
        fr_dec         = field_rem_reg - 8'd1;
        br_dec         = body_rem_reg - 8'd1;

        if (discard_reg) begin
            res_cls = dcdp_pkg::CLS_DISCARD;
            res_off = offset_reg;
            if (offset_reg != dcdp_pkg::OFFSET_MAX) begin
                offset_next = offset_reg + 8'd1;
            end
            if (s_tlast) begin
                discard_next = 1'b0;
                do_restart   = 1'b1;
            end
        end else if (phase_reg == dcdp_pkg::PH_TAG) begin
            res_cls = dcdp_pkg::CLS_TAG;
            if (s_tlast) begin
                err = dcdp_pkg::ST_TRUNC;
            end else if (s_tdata != expected_tag) begin
                err = dcdp_pkg::ST_BADTAG;
            end else begin
                phase_next = dcdp_pkg::PH_LEN;
            end
        end else if (phase_reg == dcdp_pkg::PH_LEN) begin
            res_cls = dcdp_pkg::CLS_LEN;
            if (s_tdata == 8'd0) begin
                err = dcdp_pkg::ST_ZEROLEN;
            end else if (s_tlast) begin
                err = dcdp_pkg::ST_TRUNC;
            end else begin
                body_len_next = s_tdata;
                body_rem_next = s_tdata;
                phase_next    = dcdp_pkg::PH_CID;
                offset_next   = '0;
            end
        end else begin
            res_cls = dcdp_pkg::class_t'(phase_reg);
            res_off = offset_reg;
            unique case (phase_reg)
                dcdp_pkg::PH_CID: begin
                    nxt = (offset_reg >= 8'd1) ? dcdp_pkg::PH_ENTRY : dcdp_pkg::PH_CID;
                end
                dcdp_pkg::PH_ENTRY: begin
                    nxt = dcdp_pkg::PH_SELLEN;
                end
                dcdp_pkg::PH_SELLEN: begin
                    field_rem_next = s_tdata;
                    nxt = (s_tdata != 8'd0) ? dcdp_pkg::PH_SEL : dcdp_pkg::PH_REFCNT;
                end
                dcdp_pkg::PH_SEL: begin
                    field_rem_next = fr_dec;
                    nxt = (fr_dec == 8'd0) ? dcdp_pkg::PH_REFCNT : dcdp_pkg::PH_SEL;
                end
                dcdp_pkg::PH_REFCNT: begin
                    field_rem_next = s_tdata;
                    nxt = (s_tdata != 8'd0) ? dcdp_pkg::PH_REF : dcdp_pkg::PH_LANG;
                end
                dcdp_pkg::PH_REF: begin
                    field_rem_next = fr_dec;
                    nxt = (fr_dec == 8'd0) ? dcdp_pkg::PH_LANG : dcdp_pkg::PH_REF;
                end
                dcdp_pkg::PH_LANG: begin
                    nxt = (offset_reg >= dcdp_pkg::LANG_LAST_OFFSET)
                          ? dcdp_pkg::PH_TEXTLEN : dcdp_pkg::PH_LANG;
                end
                dcdp_pkg::PH_TEXTLEN: begin
                    field_rem_next = s_tdata;
                    nxt = (s_tdata != 8'd0) ? dcdp_pkg::PH_TEXT : dcdp_pkg::PH_TRAIL;
                end
                dcdp_pkg::PH_TEXT: begin
                    field_rem_next = fr_dec;
                    nxt = (fr_dec == 8'd0) ? dcdp_pkg::PH_TRAIL : dcdp_pkg::PH_TEXT;
                end
                default: begin
                    nxt = dcdp_pkg::PH_TRAIL;
                end
            endcase
            if (nxt != phase_reg) begin
                phase_next  = nxt;
                offset_next = '0;
            end else if (offset_reg != dcdp_pkg::OFFSET_MAX) begin
                offset_next = offset_reg + 8'd1;
            end
            body_rem_next = br_dec;
            if (br_dec == 8'd0) begin
                if (nxt == dcdp_pkg::PH_TRAIL) begin
                    res_st     = dcdp_pkg::ST_OK;
                    res_done   = 1'b1;
                    res_size   = dcdp_pkg::HEADER_BYTES + {1'b0, body_len_reg};
                    do_restart = 1'b1;
                end else begin
                    err = dcdp_pkg::ST_OVERRUN;
                end
            end else if (s_tlast) begin
                err = dcdp_pkg::ST_TRUNC;
            end
        end

        if (err != dcdp_pkg::ST_BUSY) begin
            res_st       = err;
            res_done     = 1'b1;
            do_restart   = 1'b1;
            discard_next = !s_tlast;
        end

        if (do_restart) begin
            phase_next     = dcdp_pkg::PH_TAG;
            body_rem_next  = '0;
            body_len_next  = '0;
            field_rem_next = '0;
            offset_next    = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= dcdp_pkg::PH_TAG;
            body_rem_reg  <= '0;
            body_len_reg  <= '0;
            field_rem_reg <= '0;
            offset_reg    <= '0;
            discard_reg   <= 1'b0;
        end else if (accept) begin
            phase_reg     <= phase_next;
            body_rem_reg  <= body_rem_next;
            body_len_reg  <= body_len_next;
            field_rem_reg <= field_rem_next;
            offset_reg    <= offset_next;
            discard_reg   <= discard_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (accept) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // result beat payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            out_cls_reg  <= res_cls;
            out_off_reg  <= res_off;
            out_byte_reg <= s_tdata;
            out_done_reg <= res_done;
            out_st_reg   <= res_st;
            out_size_reg <= res_size;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_cls_reg;
    assign m_tlast  = out_done_reg;
    assign m_tdata  = {4'b0000, out_size_reg, out_st_reg, out_byte_reg, out_off_reg};

    `ASSERT_IMPL(a_discard_waits_tag, aclk, aresetn,
        discard_reg, phase_reg == dcdp_pkg::PH_TAG)
    `ASSERT_IMPL(a_header_counters_clear, aclk, aresetn,
        !discard_reg && (phase_reg == dcdp_pkg::PH_TAG || phase_reg == dcdp_pkg::PH_LEN),
        offset_reg == 8'd0 && body_rem_reg == 8'd0)
    `ASSERT_IMPL(a_body_not_exhausted, aclk, aresetn,
        !discard_reg && phase_reg != dcdp_pkg::PH_TAG && phase_reg != dcdp_pkg::PH_LEN,
        body_rem_reg != 8'd0)
    `ASSERT_IMPL(a_done_matches_status, aclk, aresetn,
        out_valid_reg, out_done_reg == (out_st_reg != dcdp_pkg::ST_BUSY))
    `ASSERT_IMPL(a_size_only_when_ok, aclk, aresetn,
        out_valid_reg && out_st_reg != dcdp_pkg::ST_OK, out_size_reg == 9'd0)
    `ASSERT_NEXT(a_end_of_data_stops_discard, aclk, aresetn,
        accept && s_tlast, !discard_reg)

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

typedef struct packed {
    bit [7:0] b;
    bit       eod;
} in_beat_t;

typedef struct {
    dcdp_pkg::class_t  cls;
    bit [7:0]          off;
    bit [7:0]          val;
    bit                done;
    dcdp_pkg::status_t st;
    bit [8:0]          size;
} label_t;

class label_scoreboard;
    bit [7:0]         tag_reg;
    dcdp_pkg::phase_t cur_phase;
    bit [7:0]         body_rem;
    bit [7:0]         body_len;
    bit [7:0]         fld_rem;
    bit [7:0]         offs;
    bit               discarding;
    label_t           label_q[$];
    int               errors;
    int               n_in;
    int               n_out;
    int               n_ok;
    int               n_err;
    int               n_disc;

    function new();
        tag_reg    = dcdp_pkg::EXPECTED_TAG_RESET;
        discarding = 1'b0;
        restart();
    endfunction

    function void restart();
        cur_phase = dcdp_pkg::PH_TAG;
        body_rem  = '0;
        body_len  = '0;
        fld_rem   = '0;
        offs      = '0;
    endfunction

    function int pending();
        return label_q.size();
    endfunction

    function void flag_mismatch(string msg);
        errors++;
        if (errors <= 10) begin
            $display("mismatch: %s", msg);
        end
    endfunction

    // labels one accepted input beat
    function void note_byte(bit [7:0] b, bit eod);
        label_t            e;
        dcdp_pkg::phase_t  nxt;
        dcdp_pkg::status_t err;
        e.val  = b;
        e.done = 1'b0;
        e.st   = dcdp_pkg::ST_BUSY;
        e.size = '0;
        e.off  = '0;
        err    = dcdp_pkg::ST_BUSY;
        n_in++;
        if (discarding) begin
            e.cls = dcdp_pkg::CLS_DISCARD;
            e.off = offs;
            n_disc++;
            if (offs != dcdp_pkg::OFFSET_MAX) begin
                offs++;
            end
            if (eod) begin
                discarding = 1'b0;
                restart();
            end
        end else if (cur_phase == dcdp_pkg::PH_TAG) begin
            e.cls = dcdp_pkg::CLS_TAG;
            if (eod) begin
                err = dcdp_pkg::ST_TRUNC;
            end else if (b != tag_reg) begin
                err = dcdp_pkg::ST_BADTAG;
            end else begin
                cur_phase = dcdp_pkg::PH_LEN;
            end
        end else if (cur_phase == dcdp_pkg::PH_LEN) begin
            e.cls = dcdp_pkg::CLS_LEN;
            if (b == 8'd0) begin
                err = dcdp_pkg::ST_ZEROLEN;
            end else if (eod) begin
                err = dcdp_pkg::ST_TRUNC;
            end else begin
                body_len  = b;
                body_rem  = b;
                cur_phase = dcdp_pkg::PH_CID;
                offs      = '0;
            end
        end else begin
            e.cls = dcdp_pkg::class_t'(4'(cur_phase));
            e.off = offs;
            nxt   = cur_phase;
            case (cur_phase)
                dcdp_pkg::PH_CID: begin
                    if (offs >= 8'd1) nxt = dcdp_pkg::PH_ENTRY;
                end
                dcdp_pkg::PH_ENTRY: begin
                    nxt = dcdp_pkg::PH_SELLEN;
                end
                dcdp_pkg::PH_SELLEN: begin
                    fld_rem = b;
                    nxt = (b != 0) ? dcdp_pkg::PH_SEL : dcdp_pkg::PH_REFCNT;
                end
                dcdp_pkg::PH_SEL: begin
                    fld_rem--;
                    if (fld_rem == 0) nxt = dcdp_pkg::PH_REFCNT;
                end
                dcdp_pkg::PH_REFCNT: begin
                    fld_rem = b;
                    nxt = (b != 0) ? dcdp_pkg::PH_REF : dcdp_pkg::PH_LANG;
                end
                dcdp_pkg::PH_REF: begin
                    fld_rem--;
                    if (fld_rem == 0) nxt = dcdp_pkg::PH_LANG;
                end
                dcdp_pkg::PH_LANG: begin
                    if (offs >= dcdp_pkg::LANG_LAST_OFFSET) nxt = dcdp_pkg::PH_TEXTLEN;
                end
                dcdp_pkg::PH_TEXTLEN: begin
                    fld_rem = b;
                    nxt = (b != 0) ? dcdp_pkg::PH_TEXT : dcdp_pkg::PH_TRAIL;
                end
                dcdp_pkg::PH_TEXT: begin
                    fld_rem--;
                    if (fld_rem == 0) nxt = dcdp_pkg::PH_TRAIL;
                end
                default: begin
                    nxt = dcdp_pkg::PH_TRAIL;
                end
            endcase
            if (nxt != cur_phase) begin
                cur_phase = nxt;
                offs      = '0;
            end else if (offs != dcdp_pkg::OFFSET_MAX) begin
                offs++;
            end
            body_rem--;
            if (body_rem == 0) begin
                if (cur_phase == dcdp_pkg::PH_TRAIL) begin
                    e.st   = dcdp_pkg::ST_OK;
                    e.done = 1'b1;
                    e.size = dcdp_pkg::HEADER_BYTES + 9'(body_len);
                    n_ok++;
                    restart();
                end else begin
                    err = dcdp_pkg::ST_OVERRUN;
                end
            end else if (eod) begin
                err = dcdp_pkg::ST_TRUNC;
            end
        end
        if (err != dcdp_pkg::ST_BUSY) begin
            e.st       = err;
            e.done     = 1'b1;
            n_err++;
            restart();
            discarding = !eod;
        end
        label_q.push_back(e);
    endfunction

    function void check_label(logic [31:0] d, logic [3:0] u, logic l);
        label_t e;
        n_out++;
        if (label_q.size() == 0) begin
            flag_mismatch($sformatf("unexpected result beat tdata=%h tuser=%h tlast=%b",
                                    d, u, l));
            return;
        end
        e = label_q.pop_front();
        if (u !== 4'(e.cls) || d[7:0] !== e.off || d[15:8] !== e.val ||
            d[18:16] !== 3'(e.st) || d[27:19] !== e.size || d[31:28] !== 4'd0 ||
            l !== e.done) begin
            flag_mismatch({
                $sformatf("beat %0d exp cls %0d off %0d val %h st %0d size %0d last %b",
                          n_out, e.cls, e.off, e.val, e.st, e.size, e.done),
                $sformatf(", got cls %0d off %0d val %h st %0d size %0d last %b pad %h",
                          u, d[7:0], d[15:8], d[18:16], d[27:19], l, d[31:28])});
        end
    endfunction
endclass

module tb_top;
    localparam logic [dcdp_pkg::CFG_ADDR_W-1:0] TAG_ADDR =
        (dcdp_pkg::CFG_ADDR_W)'(4 * dcdp_pkg::REG_IDX_EXPECTED_TAG);

    logic                            aclk;
    logic                            aresetn;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [7:0]                      s_tdata;
    logic                            s_tlast;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [31:0]                     m_tdata;
    logic [3:0]                      m_tuser;
    logic                            m_tlast;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [dcdp_pkg::CFG_ADDR_W-1:0] paddr;
    logic [dcdp_pkg::CFG_DATA_W-1:0] pwdata;
    logic [dcdp_pkg::CFG_DATA_W-1:0] prdata;
    logic                            pready;

    label_scoreboard sb = new();
    in_beat_t        stim_q[$];
    bit              no_idle;
    bit              hold_req;

    data_content_descriptor_parser_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #(5_000_000);
        $display("tb_top failed");
        $finish;
    end

    // beat monitor
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                sb.note_byte(s_tdata, s_tlast);
            end
            if (m_tvalid && m_tready) begin
                sb.check_label(m_tdata, m_tuser, m_tlast);
            end
        end
    end

    // result side backpressure
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_tready = 1'b0;
                repeat (80) @(negedge aclk);
                hold_req = 1'b0;
            end else begin
                m_tready = no_idle || ($urandom_range(0, 99) >= 29);
            end
        end
    end

    task automatic apb_xfer(input bit wr, input logic [dcdp_pkg::CFG_ADDR_W-1:0] addr,
                            input logic [dcdp_pkg::CFG_DATA_W-1:0] wdata,
                            output logic [dcdp_pkg::CFG_DATA_W-1:0] rdata);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = addr;
        pwdata  = wdata;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_tag(input bit [7:0] v);
        logic [dcdp_pkg::CFG_DATA_W-1:0] rd;
        apb_xfer(1'b1, TAG_ADDR, (dcdp_pkg::CFG_DATA_W)'(v), rd);
        sb.tag_reg = v;
        apb_xfer(1'b0, TAG_ADDR, '0, rd);
        if (rd[7:0] !== v) begin
            sb.flag_mismatch($sformatf("tag readback exp %h got %h", v, rd));
        end
    endtask

    task automatic wait_drain();
        while (sb.pending() != 0) @(negedge aclk);
    endtask

    task automatic add_byte(input bit [7:0] b, input bit eod);
        in_beat_t x;
        x.b   = b;
        x.eod = eod;
        stim_q.push_back(x);
    endtask

    // error tail: random discarded bytes then an end-of-data byte
    task automatic add_tail(input int cnt);
        for (int i = 0; i < cnt; i++) add_byte(8'($urandom_range(0, 255)), 1'b0);
        add_byte(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // descriptor with n selector, m reference and t text bytes, cut after nb body bytes
    task automatic add_desc(input bit [7:0] tag, input int len, input int n, input int m,
                            input int t, input int nb, input bit eod_at_cut);
        bit [7:0] body[$];
        body.push_back(8'($urandom_range(0, 255)));
        body.push_back(8'($urandom_range(0, 255)));
        body.push_back(8'($urandom_range(0, 255)));
        body.push_back(8'(n));
        for (int i = 0; i < n; i++) body.push_back(8'($urandom_range(0, 255)));
        body.push_back(8'(m));
        for (int i = 0; i < m; i++) body.push_back(8'($urandom_range(0, 255)));
        for (int i = 0; i < 3; i++) body.push_back(8'($urandom_range(0, 255)));
        body.push_back(8'(t));
        for (int i = 0; i < t; i++) body.push_back(8'($urandom_range(0, 255)));
        while (body.size() < len) body.push_back(8'($urandom_range(0, 255)));
        if (nb > len) nb = len;
        add_byte(tag, 1'b0);
        add_byte(8'(len), eod_at_cut && nb == 0);
        for (int i = 0; i < nb; i++) add_byte(body[i], eod_at_cut && i == nb - 1);
    endtask

    task automatic add_random_desc(input bit [7:0] tag);
        int kind;
        int n;
        int m;
        int t;
        int len;
        int cnt;
        bit e;
        kind = $urandom_range(0, 99);
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 4);
        m = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 4);
        t = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 4);
        len = 9 + n + m + t + $urandom_range(0, 4);
        if (kind < 60) begin
            add_desc(tag, len, n, m, t, len, $urandom_range(0, 1));
        end else if (kind < 70) begin
            add_desc(tag, len, n, m, t, $urandom_range(0, len - 1), 1'b1);
        end else if (kind < 80) begin
            len = $urandom_range(1, 8 + n + m + t);
            add_desc(tag, len, n, m, t, len, 1'b0);
            add_tail($urandom_range(0, 4));
        end else if (kind < 88) begin
            add_byte(tag ^ 8'($urandom_range(1, 255)), 1'b0);
            add_tail($urandom_range(0, 4));
        end else if (kind < 93) begin
            e = $urandom_range(0, 1);
            add_byte(tag, 1'b0);
            add_byte(8'd0, e);
            if (!e) add_tail($urandom_range(0, 4));
        end else begin
            // noise, resynced by a final end-of-data byte
            cnt = $urandom_range(1, 6);
            for (int i = 0; i < cnt; i++) begin
                add_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
            end
            add_byte(8'($urandom_range(0, 255)), 1'b1);
        end
    endtask

    // called at a falling edge
    task automatic send_stream(input int pause_at);
        for (int i = 0; i < stim_q.size(); i++) begin
            if (i == pause_at) begin
                s_tvalid = 1'b0;
                wait_drain();
            end
            while (!no_idle && $urandom_range(0, 99) < 29) begin
                s_tvalid = 1'b0;
                @(negedge aclk);
            end
            s_tvalid = 1'b1;
            s_tdata  = stim_q[i].b;
            s_tlast  = stim_q[i].eod;
            do @(posedge aclk); while (!s_tready);
            @(negedge aclk);
        end
        s_tvalid = 1'b0;
    endtask

    initial begin
        logic [dcdp_pkg::CFG_DATA_W-1:0] rd;
        bit [7:0]                        tag;
        int                              n_tags;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        no_idle  = 1'b0;
        hold_req = 1'b0;
        n_tags   = 1;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        apb_xfer(1'b0, TAG_ADDR, '0, rd);
        if (rd[7:0] !== dcdp_pkg::EXPECTED_TAG_RESET) begin
            sb.flag_mismatch($sformatf("tag reset value exp %h got %h",
                                       dcdp_pkg::EXPECTED_TAG_RESET, rd));
        end

        // directed
        tag = dcdp_pkg::EXPECTED_TAG_RESET;
        add_byte(8'h00, 1'b1);
        add_byte(8'hFF, 1'b0);
        add_byte(8'h5A, 1'b0);
        add_byte(8'hA5, 1'b1);
        add_byte(tag, 1'b0);
        add_byte(8'h00, 1'b1);
        add_byte(tag, 1'b0);
        add_byte(8'h05, 1'b1);
        add_byte(tag, 1'b0);
        add_byte(8'h01, 1'b0);
        add_byte(8'hFF, 1'b1);
        add_desc(tag, 9, 0, 0, 0, 9, 1'b1);
        send_stream(-1);
        wait_drain();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: tag = 8'h00;
                1: tag = 8'hFF;
                2: tag = 8'($urandom_range(1, 254));
                default: tag = dcdp_pkg::EXPECTED_TAG_RESET;
            endcase
            repeat (3) @(negedge aclk);
            set_tag(tag);
            n_tags++;
            no_idle = (ph == 1);
            stim_q.delete();
            if (ph == 1) begin
                add_desc(tag, 255, 100, 100, 46, 255, 1'b0);
            end
            if (ph == 2) begin
                add_byte(~tag, 1'b0);
                add_tail(300);
            end
            while (stim_q.size() < 120) add_random_desc(tag);
            if (ph == 0) hold_req = 1'b1;
            send_stream(stim_q.size() / 2);
            wait_drain();
        end
        no_idle = 1'b0;
        repeat (5) @(posedge aclk);

        $display("run: %0d bytes in, %0d labels checked, %0d tag settings",
                 sb.n_in, sb.n_out, n_tags);
        $display("run: %0d descriptors ok, %0d error endings, %0d bytes discarded",
                 sb.n_ok, sb.n_err, sb.n_disc);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end
endmodule

// ----- files.f -----
+incdir+rtl
rtl/dcdp_pkg.sv
rtl/dcdp_cfg.sv
rtl/data_content_descriptor_parser_unit.sv
tb/tb_top.sv
